@@ hw/rtl/tbp_pkg.sv @@
// Shared types, constants and counter helpers for the tournament branch predictor.
// Depends on nothing; tbp_eval and the top level import it, tbp_ram does not.
package tbp_pkg;

  localparam int BIM_BITS  = 14;
  localparam int HIST_BITS = 14;
  localparam int CLR_BITS  = (BIM_BITS > HIST_BITS) ? BIM_BITS : HIST_BITS;

  localparam logic [1:0] BIM_RESET = 2'd2;
  localparam logic [1:0] GSH_RESET = 2'd1;
  localparam logic [1:0] CHO_RESET = 2'd1;
  localparam logic [1:0] CNT_MAX   = 2'd3;
  localparam logic [1:0] CNT_MIN   = 2'd0;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  typedef struct packed {
    logic       pred_taken;
    logic       use_global;
    logic [1:0] bim_next;
    logic [1:0] gsh_next;
    logic [1:0] cho_next;
  } eval_t;

  function automatic logic [1:0] sat_move(input logic [1:0] cnt, input logic up);
    logic [1:0] res;
    if (up) begin
      res = (cnt == CNT_MAX) ? CNT_MAX : cnt + 2'd1;
    end else begin
      res = (cnt == CNT_MIN) ? CNT_MIN : cnt - 2'd1;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/tbp_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module tbp_ram #(
  parameter int ADDR_BITS = 14,
  parameter int DATA_BITS = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tbp_eval.sv @@
// Prediction and counter update logic applied to the counters read from the tables.
// Depends on tbp_pkg for the result struct and the saturating counter function.
module tbp_eval (
  input  logic [1:0]    bim_cnt,
  input  logic [1:0]    gsh_cnt,
  input  logic [1:0]    cho_cnt,
  input  logic          taken,
  output tbp_pkg::eval_t res
);
  import tbp_pkg::*;

  logic bim_pred;
  logic gsh_pred;
  logic g_ok;
  logic b_ok;

  always_comb begin
    bim_pred       = bim_cnt[1];
    gsh_pred       = gsh_cnt[1];
    g_ok           = (gsh_pred == taken);
    b_ok           = (bim_pred == taken);
    res.use_global = cho_cnt[1];
    res.pred_taken = cho_cnt[1] ? gsh_pred : bim_pred;
    res.bim_next   = sat_move(bim_cnt, taken);
    res.gsh_next   = sat_move(gsh_cnt, taken);
    if (g_ok && !b_ok) begin
      res.cho_next = sat_move(cho_cnt, 1'b1);
    end else if (!g_ok && b_ok) begin
      res.cho_next = sat_move(cho_cnt, 1'b0);
    end else begin
      res.cho_next = cho_cnt;
    end
  end

endmodule

@@ hw/rtl/tournament_branch_predictor.sv @@
// Tournament branch predictor: top level with control, history and the two tables.
// Depends on tbp_pkg, tbp_ram and tbp_eval.
// Output: out_valid is registered when a prediction leaves the lookup state; updates give none.
// A new transaction is taken only once the last has left the lookup state (read-modify-write).
// Reset: the history clears at once, then a clearing pass over all 2^14 entries loads the
// counter reset values while in_stall stays high.
module tournament_branch_predictor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] pc,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        predicted_taken,
  output logic        used_global
);
  import tbp_pkg::*;

  localparam logic [CLR_BITS:0] BIM_LIMIT  = (CLR_BITS+1)'(1) << BIM_BITS;
  localparam logic [CLR_BITS:0] HIST_LIMIT = (CLR_BITS+1)'(1) << HIST_BITS;

  state_t               state;
  logic [CLR_BITS-1:0]  clr_idx;
  logic [HIST_BITS-1:0] history;
  logic [BIM_BITS-1:0]  bi;
  logic [HIST_BITS-1:0] gi;
  logic                 op;
  logic                 outcome;

  logic                 accept;
  logic                 out_free;
  logic                 bim_we;
  logic                 glb_we;
  logic [BIM_BITS-1:0]  bim_waddr;
  logic [HIST_BITS-1:0] glb_waddr;
  logic [1:0]           bim_wdata;
  logic [3:0]           glb_wdata;
  logic [BIM_BITS-1:0]  bim_raddr;
  logic [HIST_BITS-1:0] glb_raddr;
  logic [1:0]           bim_rdata;
  logic [3:0]           glb_rdata;
  eval_t                res;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign bim_raddr = pc[BIM_BITS-1:0];
  assign glb_raddr = pc[HIST_BITS-1:0] ^ history;

  always_comb begin
    bim_we    = 1'b0;
    glb_we    = 1'b0;
    bim_waddr = bi;
    glb_waddr = gi;
    bim_wdata = res.bim_next;
    glb_wdata = {res.gsh_next, res.cho_next};
    case (state)
      ST_CLEAR: begin
        bim_we    = {1'b0, clr_idx} < BIM_LIMIT;
        glb_we    = {1'b0, clr_idx} < HIST_LIMIT;
        bim_waddr = clr_idx[BIM_BITS-1:0];
        glb_waddr = clr_idx[HIST_BITS-1:0];
        bim_wdata = BIM_RESET;
        glb_wdata = {GSH_RESET, CHO_RESET};
      end
      ST_LOOKUP: begin
        bim_we = (op == OP_UPDATE);
        glb_we = (op == OP_UPDATE);
      end
      default: begin
        bim_we = 1'b0;
        glb_we = 1'b0;
      end
    endcase
  end

  tbp_ram #(
    .ADDR_BITS (BIM_BITS),
    .DATA_BITS (2)
  ) u_bim_ram (
    .clk   (clk),
    .we    (bim_we),
    .waddr (bim_waddr),
    .wdata (bim_wdata),
    .re    (accept),
    .raddr (bim_raddr),
    .rdata (bim_rdata)
  );

  tbp_ram #(
    .ADDR_BITS (HIST_BITS),
    .DATA_BITS (4)
  ) u_glb_ram (
    .clk   (clk),
    .we    (glb_we),
    .waddr (glb_waddr),
    .wdata (glb_wdata),
    .re    (accept),
    .raddr (glb_raddr),
    .rdata (glb_rdata)
  );

  tbp_eval u_eval (
    .bim_cnt (bim_rdata),
    .gsh_cnt (glb_rdata[3:2]),
    .cho_cnt (glb_rdata[1:0]),
    .taken   (outcome),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      bi      <= bim_raddr;
      gi      <= glb_raddr;
      op      <= opcode;
      outcome <= taken;
    end
    if (state == ST_LOOKUP && op == OP_PREDICT && out_free) begin
      predicted_taken <= res.pred_taken;
      used_global     <= res.use_global;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      history   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_LOOKUP && op == OP_PREDICT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + CLR_BITS'(1);
          if (&clr_idx) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (op == OP_UPDATE) begin
            history <= {history[HIST_BITS-2:0], outcome};
            state   <= ST_IDLE;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule
